@@ sv/kdmr_pkg.sv @@
// shared constants and types for the key debounce and matrix refresh block
`timescale 1ns / 1ps
`default_nettype none

package kdmr_pkg;

   localparam int NUM_KEYS    = 4;
   localparam int MATRIX_SIZE = 8;
   localparam int SCAN_STEPS  = 2 * MATRIX_SIZE;
   localparam int SCAN_W      = $clog2(SCAN_STEPS);
   localparam int FRAME_IDX_W = SCAN_W - 1;

   localparam int COUNT_W     = 8;
   localparam int COL_IDX_W   = 3;
   localparam int COL_BITS_W  = 8;
   localparam int WORD_W      = 16;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_ADDR_W-3:0] HOLD_TICKS_IDX = '0;
   localparam logic [COUNT_W-1:0]    HOLD_RESET     = 8'd5;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef struct packed {
      logic [NUM_KEYS-1:0] changed;
      logic [NUM_KEYS-1:0] toggle;
      logic [NUM_KEYS-1:0] stable;
   } key_status_type;

   typedef struct packed {
      logic              word_valid;
      logic [WORD_W-1:0] serial_word;
      logic              latch_level;
   } scan_status_type;

endpackage

`default_nettype wire

@@ sv/key_debounce_matrix_refresh.sv @@
// top level: request register, debounce and scan logic, result register, csr port
`timescale 1ns / 1ps
`default_nettype none

// Debounces four keys and drives an 8x8 LED matrix scan, one result per request.
// A tick request updates the key debouncers and, when the serial link is idle,
// steps the 16-step scan (even steps send a column word with the latch low, odd
// steps raise the latch). A write request loads one frame column. Requests pass
// through an input register and a result register, so a new request is taken
// every cycle while results are taken; a stalled result holds the input. The
// result is registered once the input register advances to it. hold_ticks sits at
// byte address 0 of the csr port and resets to 5; write it only while idle.
module key_debounce_matrix_refresh (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_op,
   input  wire logic [kdmr_pkg::NUM_KEYS-1:0]      req_raw_keys,
   input  wire logic                               req_spi_busy,
   input  wire logic [kdmr_pkg::COL_IDX_W-1:0]     req_column_index,
   input  wire logic [kdmr_pkg::COL_BITS_W-1:0]    req_column_bits,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [kdmr_pkg::NUM_KEYS-1:0]           rsp_key_changed,
   output logic [kdmr_pkg::NUM_KEYS-1:0]           rsp_key_toggle,
   output logic [kdmr_pkg::NUM_KEYS-1:0]           rsp_key_stable,
   output logic                                    rsp_word_valid,
   output logic [kdmr_pkg::WORD_W-1:0]             rsp_serial_word,
   output logic                                    rsp_latch_level,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [kdmr_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [kdmr_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [kdmr_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                    pready
);
   import kdmr_pkg::*;

   logic [COUNT_W-1:0]    hold_ticks_ff;
   logic                  hold_sel;

   logic                  in_valid_ff;
   logic                  in_op_ff;
   logic [NUM_KEYS-1:0]   in_raw_ff;
   logic                  in_busy_ff;
   logic [COL_IDX_W-1:0]  in_col_idx_ff;
   logic [COL_BITS_W-1:0] in_col_bits_ff;

   logic                  rsp_valid_ff;
   key_status_type        key_ff;
   scan_status_type       scan_ff;

   logic                  advance;
   logic                  is_tick;
   key_status_type        key_status;
   scan_status_type       scan_status;

   assign pready   = 1'b1;
   assign hold_sel = paddr[CSR_ADDR_W-1:2] == HOLD_TICKS_IDX;
   assign prdata   = hold_sel ? CSR_DATA_W'(hold_ticks_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff <= HOLD_RESET;
      end else if (psel && penable && pwrite && pready && hold_sel) begin
         hold_ticks_ff <= pwdata[COUNT_W-1:0];
      end
   end

   assign advance   = in_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign is_tick   = in_op_ff == OP_TICK;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff       <= req_op;
         in_raw_ff      <= req_raw_keys;
         in_busy_ff     <= req_spi_busy;
         in_col_idx_ff  <= req_column_index;
         in_col_bits_ff <= req_column_bits;
      end
   end

   kdmr_debounce u_debounce (
      .clock      (clock),
      .reset      (reset),
      .tick_en    (advance & is_tick),
      .is_tick    (is_tick),
      .raw_keys   (in_raw_ff),
      .hold_ticks (hold_ticks_ff),
      .status     (key_status)
   );

   kdmr_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .tick_en      (advance & is_tick),
      .write_en     (advance & (in_op_ff == OP_WRITE)),
      .is_tick      (is_tick),
      .spi_busy     (in_busy_ff),
      .column_index (in_col_idx_ff),
      .column_bits  (in_col_bits_ff),
      .status       (scan_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         key_ff  <= key_status;
         scan_ff <= scan_status;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_key_changed = key_ff.changed;
   assign rsp_key_toggle  = key_ff.toggle;
   assign rsp_key_stable  = key_ff.stable;
   assign rsp_word_valid  = scan_ff.word_valid;
   assign rsp_serial_word = scan_ff.serial_word;
   assign rsp_latch_level = scan_ff.latch_level;

   a_word_latch_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word_valid |-> !rsp_latch_level)
      else $error("word sent with latch high");

   a_word_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word_valid |-> $onehot(rsp_serial_word[COL_BITS_W-1:0]))
      else $error("column select not one-hot");

   a_no_word_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word_valid |-> rsp_serial_word == '0)
      else $error("serial word nonzero without send");

   a_changed_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_key_changed & ~rsp_key_stable) == '0)
      else $error("press pulse on a key that is not stable high");

endmodule

`default_nettype wire

@@ sv/kdmr_debounce.sv @@
// per-key edge detect, quiet counters, stable level and toggle bits
`timescale 1ns / 1ps
`default_nettype none

module kdmr_debounce (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         tick_en,
   input  wire logic                         is_tick,
   input  wire logic [kdmr_pkg::NUM_KEYS-1:0] raw_keys,
   input  wire logic [kdmr_pkg::COUNT_W-1:0]  hold_ticks,
   output kdmr_pkg::key_status_type          status
);
   import kdmr_pkg::*;

   logic [NUM_KEYS-1:0] prev_raw_ff;
   logic [COUNT_W-1:0]  count_ff [NUM_KEYS];
   logic [COUNT_W-1:0]  count_in [NUM_KEYS];
   logic [NUM_KEYS-1:0] stable_ff, stable_in;
   logic [NUM_KEYS-1:0] toggle_ff, toggle_in;
   logic [NUM_KEYS-1:0] changed;

   always_comb begin
      logic [COUNT_W:0] inc;
      stable_in = stable_ff;
      toggle_in = toggle_ff;
      changed   = '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         inc = {1'b0, count_ff[k]} + 1'b1;
         if (raw_keys[k] != prev_raw_ff[k]) begin
            count_in[k] = '0;
         end else if (inc > {1'b0, hold_ticks}) begin
            count_in[k] = hold_ticks;
         end else begin
            count_in[k] = inc[COUNT_W-1:0];
         end
         if (count_in[k] == hold_ticks && stable_ff[k] != raw_keys[k]) begin
            stable_in[k] = raw_keys[k];
            if (raw_keys[k]) begin
               toggle_in[k] = ~toggle_ff[k];
               changed[k]   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_raw_ff <= '0;
         stable_ff   <= '0;
         toggle_ff   <= '0;
         for (int k = 0; k < NUM_KEYS; k++) begin
            count_ff[k] <= '0;
         end
      end else if (tick_en) begin
         prev_raw_ff <= raw_keys;
         stable_ff   <= stable_in;
         toggle_ff   <= toggle_in;
         for (int k = 0; k < NUM_KEYS; k++) begin
            count_ff[k] <= count_in[k];
         end
      end
   end

   always_comb begin
      if (is_tick) begin
         status.changed = changed;
         status.toggle  = toggle_in;
         status.stable  = stable_in;
      end else begin
         status.changed = '0;
         status.toggle  = toggle_ff;
         status.stable  = stable_ff;
      end
   end

endmodule

`default_nettype wire

@@ sv/kdmr_scan.sv @@
// frame store and matrix scan sequencer with latch control
`timescale 1ns / 1ps
`default_nettype none

module kdmr_scan (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            tick_en,
   input  wire logic                            write_en,
   input  wire logic                            is_tick,
   input  wire logic                            spi_busy,
   input  wire logic [kdmr_pkg::COL_IDX_W-1:0]  column_index,
   input  wire logic [kdmr_pkg::COL_BITS_W-1:0] column_bits,
   output kdmr_pkg::scan_status_type            status
);
   import kdmr_pkg::*;

   logic [MATRIX_SIZE-1:0] frame_ff [MATRIX_SIZE];
   logic [SCAN_W-1:0]      step_ff, step_in, step_cur;
   logic                   latch_ff, latch_in;
   logic [FRAME_IDX_W-1:0] col;
   logic                   send;
   logic [WORD_W-1:0]      word;

   always_comb begin
      logic [SCAN_W:0] nxt;
      step_cur = (step_ff >= SCAN_STEPS) ? '0 : step_ff;
      col      = step_cur[SCAN_W-1:1];
      nxt      = {1'b0, step_cur} + 1'b1;
      step_in  = (nxt >= SCAN_STEPS) ? '0 : nxt[SCAN_W-1:0];
      send     = ~spi_busy & ~step_cur[0];
      latch_in = spi_busy ? latch_ff : step_cur[0];
      word     = {COL_BITS_W'(frame_ff[col]), COL_BITS_W'(1) << col};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         latch_ff <= 1'b0;
         for (int c = 0; c < MATRIX_SIZE; c++) begin
            frame_ff[c] <= '0;
         end
      end else begin
         if (tick_en && !spi_busy) begin
            step_ff  <= step_in;
            latch_ff <= latch_in;
         end
         if (write_en && column_index < MATRIX_SIZE) begin
            frame_ff[column_index[FRAME_IDX_W-1:0]] <= column_bits[MATRIX_SIZE-1:0];
         end
      end
   end

   always_comb begin
      if (is_tick) begin
         status.word_valid  = send;
         status.serial_word = send ? word : '0;
         status.latch_level = latch_in;
      end else begin
         status.word_valid  = 1'b0;
         status.serial_word = '0;
         status.latch_level = latch_ff;
      end
   end

endmodule

`default_nettype wire
